>>> rtl/jsu_pkg.sv
// Shared types and character constants for the JSON string unescaper.
package jsu_pkg;

  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChSlash     = 8'h2F;
  localparam logic [7:0] ChB         = 8'h62;
  localparam logic [7:0] ChF         = 8'h66;
  localparam logic [7:0] ChN         = 8'h6E;
  localparam logic [7:0] ChR         = 8'h72;
  localparam logic [7:0] ChT         = 8'h74;
  localparam logic [7:0] ChU         = 8'h75;
  localparam logic [7:0] Ch0         = 8'h30;
  localparam logic [7:0] Ch9         = 8'h39;
  localparam logic [7:0] ChUpperA    = 8'h41;
  localparam logic [7:0] ChLowerA    = 8'h61;
  localparam logic [7:0] ChLowerZ    = 8'h7A;
  localparam logic [7:0] CaseOffset  = 8'h20;
  localparam logic [7:0] HexTen      = 8'd10;

  localparam logic [7:0] CtlBackspace = 8'h08;
  localparam logic [7:0] CtlFormFeed  = 8'h0C;
  localparam logic [7:0] CtlNewline   = 8'h0A;
  localparam logic [7:0] CtlReturn    = 8'h0D;
  localparam logic [7:0] CtlTab       = 8'h09;

  localparam logic [2:0] HexDigits = 3'd4;

  typedef struct packed {
    logic        esc;
    logic        hex;
    logic [2:0]  digits;
    logic [15:0] code;
  } dec_state_t;

  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      nbytes;
    logic            has_byte;
    logic            last;
  } grp_t;

endpackage

>>> rtl/jsu_decode.sv
// Per-byte decode: escape state update and the group of output bytes it yields.
module jsu_decode
  import jsu_pkg::*;
(
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  input  dec_state_t  state,
  output dec_state_t  state_next,
  output grp_t        grp,
  output logic        emit
);

  logic [7:0]  upper;
  logic [3:0]  digit;
  logic [15:0] code_shift;
  logic [2:0]  digits_inc;
  logic        emit_utf8;
  logic        emit_single;
  logic [7:0]  single;
  logic [15:0] u_code;
  dec_state_t  st;

  always_comb begin
    upper = ((in_byte >= ChLowerA) && (in_byte <= ChLowerZ)) ? (in_byte - CaseOffset) : in_byte;
    if ((in_byte >= Ch0) && (in_byte <= Ch9)) begin
      digit = 4'(in_byte - Ch0);
    end else begin
      digit = 4'(upper - ChUpperA + HexTen);
    end
    code_shift = {state.code[11:0], digit};
    digits_inc = state.digits + 3'd1;
  end

  always_comb begin
    st          = state;
    emit_utf8   = 1'b0;
    emit_single = 1'b0;
    single      = in_byte;
    u_code      = state.code;
    if (state.hex) begin
      st.code   = code_shift;
      st.digits = digits_inc;
      u_code    = code_shift;
      if (digits_inc >= HexDigits) begin
        emit_utf8 = 1'b1;
        st.hex    = 1'b0;
        st.digits = '0;
        st.code   = '0;
      end
    end else if (state.esc) begin
      st.esc = 1'b0;
      unique case (in_byte)
        ChBackslash, ChQuote, ChSlash: emit_single = 1'b1;
        ChB: begin emit_single = 1'b1; single = CtlBackspace; end
        ChF: begin emit_single = 1'b1; single = CtlFormFeed;  end
        ChN: begin emit_single = 1'b1; single = CtlNewline;   end
        ChR: begin emit_single = 1'b1; single = CtlReturn;    end
        ChT: begin emit_single = 1'b1; single = CtlTab;       end
        ChU: begin
          st.hex    = 1'b1;
          st.digits = '0;
          st.code   = '0;
        end
        default: ;
      endcase
    end else if (in_byte == ChBackslash) begin
      st.esc = 1'b1;
    end else begin
      emit_single = 1'b1;
    end

    if (in_last && st.hex) begin
      emit_utf8 = 1'b1;
      u_code    = st.code;
    end
  end

  always_comb begin
    grp          = '0;
    grp.last     = in_last;
    grp.has_byte = 1'b1;
    grp.nbytes   = 2'd1;
    if (emit_utf8) begin
      if (u_code < 16'h0080) begin
        grp.bytes[0] = u_code[7:0];
      end else if (u_code < 16'h0800) begin
        grp.nbytes   = 2'd2;
        grp.bytes[0] = {3'b110, u_code[10:6]};
        grp.bytes[1] = {2'b10, u_code[5:0]};
      end else begin
        grp.nbytes   = 2'd3;
        grp.bytes[0] = {4'b1110, u_code[15:12]};
        grp.bytes[1] = {2'b10, u_code[11:6]};
        grp.bytes[2] = {2'b10, u_code[5:0]};
      end
    end else if (emit_single) begin
      grp.bytes[0] = single;
    end else begin
      grp.has_byte = 1'b0;
    end
    emit = emit_utf8 || emit_single || in_last;
    state_next = in_last ? dec_state_t'('0) : st;
  end

endmodule

>>> rtl/json_string_unescape.sv
// Top level of the streaming JSON string unescaper.
//
// Input channel (in_valid / in_stall): one escaped byte of a string body per
// transfer, in_last on the final byte. Output channel (res_valid / res_stall):
// one decoded byte per transfer on out_byte with out_valid high, or an empty
// marker (out_valid low, out_byte zero) when the final input byte yields
// nothing. out_last marks the last result of the string.
// An accepted byte is registered in the input register, decoded against the
// escape state into a group of zero to three bytes, and the group is written
// to a two-entry group queue when that queue has room. The input register and
// the queue entry lie between a transfer and the first result of its item.
// While the receiver does not stall, groups are drained one byte per cycle, so
// the block takes one input byte per cycle while each byte yields at most one
// result; a \u escape yielding two or three bytes holds the input as they drain.
// Reset empties the input register and the queue and clears the escape state.
// While the receiver stalls, the head result holds; the queue fills and the
// input stalls once both entries and the input register are occupied.
module json_string_unescape
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       res_valid,
  input  logic       res_stall,
  output logic [7:0] out_byte,
  output logic       out_valid,
  output logic       out_last
);

  logic       ireg_valid;
  logic [7:0] ireg_byte;
  logic       ireg_last;

  dec_state_t state;
  dec_state_t state_next;
  grp_t       grp;
  logic       emit;

  grp_t       queue [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic [1:0] idx;
  grp_t       head;
  logic       adv;
  logic       push;
  logic       pop;
  logic       head_end;

  jsu_decode u_decode (
    .in_byte    (ireg_byte),
    .in_last    (ireg_last),
    .state      (state),
    .state_next (state_next),
    .grp        (grp),
    .emit       (emit)
  );

  assign adv      = ireg_valid && (count != 2'd2);
  assign in_stall = ireg_valid && !adv;
  assign push     = adv && emit;

  assign head      = queue[rd_ptr];
  assign head_end  = (idx == (head.nbytes - 2'd1));
  assign res_valid = (count != 2'd0);
  assign pop       = res_valid && !res_stall && head_end;
  assign out_byte  = head.bytes[idx];
  assign out_valid = head.has_byte;
  assign out_last  = head.last && head_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      ireg_valid <= 1'b0;
    end else if (!in_stall) begin
      ireg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      ireg_byte <= in_byte;
      ireg_last <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (adv) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= grp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
      idx    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
      if (res_valid && !res_stall) begin
        idx <= head_end ? 2'd0 : (idx + 2'd1);
      end
    end
  end

endmodule

>>> rtl/jsu_checker.sv
// Port-level checks for the JSON string unescaper and their bind.
module jsu_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       res_valid,
  input logic       res_stall,
  input logic [7:0] out_byte,
  input logic       out_valid,
  input logic       out_last
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(out_byte) && $stable(out_valid)
      && $stable(out_last))
    else $error("result changed while stalled");

  a_marker: assert property (@(posedge clk) disable iff (rst)
    res_valid && !out_valid |-> out_last && (out_byte == 8'h00))
    else $error("empty marker without last or with data");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid && !in_stall)
    else $error("block not empty after reset");

  a_idle_no_stall: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> !in_stall)
    else $error("input stalled while output queue empty");

endmodule

bind json_string_unescape jsu_checker u_jsu_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .out_byte  (out_byte),
  .out_valid (out_valid),
  .out_last  (out_last)
);
